>>> hdl/cfim_pkg.sv
// Shared constants, types and the arctangent table of the cube face inverse map.
`timescale 1ns / 1ps

package cfim_pkg;

    // Component width and CORDIC depth
    localparam int COORD_WIDTH  = 16;
    localparam int CORDIC_STEPS = 16;

    // Operands after the axis pick carry one extra bit so that negation is exact
    localparam int DATA_WIDTH   = COORD_WIDTH + 1;

    // Operands are scaled up by 2^PRESHIFT before the rotations
    localparam int PRESHIFT     = 24;

    // Rotation datapath: scaled operand plus headroom for the CORDIC gain
    localparam int XY_WIDTH     = DATA_WIDTH + PRESHIFT + 2;

    // Angle accumulator in units of 2^-30 rad
    localparam int TAB_WIDTH    = 30;
    localparam int Z_WIDTH      = TAB_WIDTH + 3;

    // Result angle, radians in Q1.15
    localparam int ANGLE_WIDTH  = 16;
    localparam int ANGLE_FRAC   = 15;
    localparam logic [ANGLE_WIDTH-1:0] QUARTER_PI_Q15 = ANGLE_WIDTH'(25736);

    // Face codes
    localparam int FACE_WIDTH = 3;
    localparam logic [FACE_WIDTH-1:0] FACE_POS_X = 3'd0;
    localparam logic [FACE_WIDTH-1:0] FACE_POS_Y = 3'd1;
    localparam logic [FACE_WIDTH-1:0] FACE_NEG_X = 3'd2;
    localparam logic [FACE_WIDTH-1:0] FACE_NEG_Y = 3'd3;
    localparam logic [FACE_WIDTH-1:0] FACE_POS_Z = 3'd4;
    localparam logic [FACE_WIDTH-1:0] FACE_NEG_Z = 3'd5;

    // One arctangent lane in flight
    typedef struct packed {
        logic signed [XY_WIDTH-1:0] x;
        logic signed [XY_WIDTH-1:0] y;
        logic signed [Z_WIDTH-1:0]  z;
        logic                       neg;   // tangent component was negative
        logic                       zero;  // tangent component was zero
        logic                       diag;  // |tangent| equals the normal
    } t_lane;

    // atan(2^-i) in units of 2^-30 rad
    function automatic logic [TAB_WIDTH-1:0] atan_entry(input int unsigned idx);
        logic [TAB_WIDTH-1:0] v;
        case (idx)
            0:  v = 30'h3243F6A8;
            1:  v = 30'h1DAC6705;
            2:  v = 30'h0FADBAFC;
            3:  v = 30'h07F56EA6;
            4:  v = 30'h03FEAB76;
            5:  v = 30'h01FFD55B;
            6:  v = 30'h00FFFAAA;
            7:  v = 30'h007FFF55;
            8:  v = 30'h003FFFEA;
            9:  v = 30'h001FFFFD;
            10: v = 30'h000FFFFF;
            11: v = 30'h0007FFFF;
            12: v = 30'h0003FFFF;
            13: v = 30'h0001FFFF;
            14: v = 30'h0000FFFF;
            15: v = 30'h00007FFF;
            16: v = 30'h00003FFF;
            17: v = 30'h00001FFF;
            18: v = 30'h00000FFF;
            19: v = 30'h000007FF;
            20: v = 30'h000003FF;
            21: v = 30'h000001FF;
            22: v = 30'h000000FF;
            23: v = 30'h0000007F;
            24: v = 30'h0000003F;
            25: v = 30'h0000001F;
            26: v = 30'h0000000F;
            27: v = 30'h00000008;
            28: v = 30'h00000004;
            29: v = 30'h00000002;
            30: v = 30'h00000001;
            default: v = 30'h00000000;
        endcase
        return v;
    endfunction

endpackage

>>> hdl/cube_face_inverse_map_unit.sv
// Top level of the cube face inverse map: face pick, basis selection and two CORDIC lanes.
`timescale 1ns / 1ps

// Fully pipelined: a transaction is taken on every cycle that start is high (busy is
// always low), and its result appears on the output ports, marked by o_result_valid,
// for exactly one cycle, after input capture, face selection, lane setup, the CORDIC
// chain of one rotation stage per step, and output rounding. Results must be taken
// when shown; the receiver cannot stall the pipeline. A zero vector sets o_zero_vector
// with face and angles zero.
module cube_face_inverse_map_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [cfim_pkg::COORD_WIDTH-1:0] i_pos_x,
    input  logic signed [cfim_pkg::COORD_WIDTH-1:0] i_pos_y,
    input  logic signed [cfim_pkg::COORD_WIDTH-1:0] i_pos_z,
    output logic                                 o_result_valid,
    output logic [cfim_pkg::FACE_WIDTH-1:0]      o_face,
    output logic signed [cfim_pkg::ANGLE_WIDTH-1:0] o_angle_a,
    output logic signed [cfim_pkg::ANGLE_WIDTH-1:0] o_angle_b,
    output logic                                 o_zero_vector
);

    localparam int CW    = cfim_pkg::COORD_WIDTH;
    localparam int DW    = cfim_pkg::DATA_WIDTH;
    localparam int XW    = cfim_pkg::XY_WIDTH;
    localparam int ZW    = cfim_pkg::Z_WIDTH;
    localparam int AW    = cfim_pkg::ANGLE_WIDTH;
    localparam int FW    = cfim_pkg::FACE_WIDTH;
    localparam int STEPS = cfim_pkg::CORDIC_STEPS;
    localparam int QW    = ZW - cfim_pkg::ANGLE_FRAC;

    // One vectoring rotation; both updates use the old x and y
    function automatic cfim_pkg::t_lane cordic_step(input cfim_pkg::t_lane l,
                                                    input int unsigned idx);
        cfim_pkg::t_lane r;
        logic signed [ZW-1:0] ang;
        r   = l;
        ang = ZW'($signed({1'b0, cfim_pkg::atan_entry(idx)}));
        if (!l.y[XW-1]) begin
            r.x = l.x + (l.y >>> idx);
            r.y = l.y - (l.x >>> idx);
            r.z = l.z + ang;
        end else begin
            r.x = l.x - (l.y >>> idx);
            r.y = l.y + (l.x >>> idx);
            r.z = l.z - ang;
        end
        return r;
    endfunction

    // Set up one lane from the normal and a tangent component
    function automatic cfim_pkg::t_lane lane_init(input logic [DW-1:0] n,
                                                  input logic signed [DW-1:0] t);
        cfim_pkg::t_lane r;
        logic [DW-1:0] m;
        m      = t[DW-1] ? DW'(-t) : DW'(t);
        r.x    = $signed({{(XW-DW-cfim_pkg::PRESHIFT){1'b0}}, n,
                          {cfim_pkg::PRESHIFT{1'b0}}});
        r.y    = $signed({{(XW-DW-cfim_pkg::PRESHIFT){1'b0}}, m,
                          {cfim_pkg::PRESHIFT{1'b0}}});
        r.z    = '0;
        r.neg  = t[DW-1];
        r.zero = (m == '0);
        r.diag = (m == n);
        return r;
    endfunction

    // Round the accumulated angle to Q1.15, clamp and apply the tangent sign
    function automatic logic [AW-1:0] lane_result(input cfim_pkg::t_lane l);
        logic signed [ZW-1:0] zr;
        logic signed [QW-1:0] q;
        logic [AW-1:0]        mag;
        zr = l.z + ZW'(1 << (cfim_pkg::ANGLE_FRAC - 1));
        q  = zr[ZW-1:cfim_pkg::ANGLE_FRAC];
        if (l.zero) begin
            mag = '0;
        end else if (l.diag) begin
            mag = cfim_pkg::QUARTER_PI_Q15;
        end else if (q < 0) begin
            mag = '0;
        end else if (q > $signed({{(QW-AW){1'b0}}, cfim_pkg::QUARTER_PI_Q15})) begin
            mag = cfim_pkg::QUARTER_PI_Q15;
        end else begin
            mag = q[AW-1:0];
        end
        return l.neg ? AW'(-mag) : mag;
    endfunction

    // The pipeline never stalls
    assign busy = 1'b0;

    // Stage 1: capture the input transaction
    logic                 r_s1_vld;
    logic signed [CW-1:0] r_s1_x, r_s1_y, r_s1_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= start && !busy;
        end
        r_s1_x <= i_pos_x;
        r_s1_y <= i_pos_y;
        r_s1_z <= i_pos_z;
    end

    // Stage 2: pick the face and apply its basis
    logic signed [DW-1:0] ex, ey, ez;
    logic [DW-1:0]        mx, my, mz, mxy;
    logic [FW-1:0]        n_face;
    logic [DW-1:0]        n_norm;
    logic signed [DW-1:0] n_ta, n_tb;

    always_comb begin
        ex  = DW'(r_s1_x);
        ey  = DW'(r_s1_y);
        ez  = DW'(r_s1_z);
        mx  = ex[DW-1] ? DW'(-ex) : DW'(ex);
        my  = ey[DW-1] ? DW'(-ey) : DW'(ey);
        mz  = ez[DW-1] ? DW'(-ez) : DW'(ez);
        mxy = (my > mx) ? my : mx;
        if (mz > mxy) begin
            n_face = ez[DW-1] ? cfim_pkg::FACE_NEG_Z : cfim_pkg::FACE_POS_Z;
        end else if (my > mx) begin
            n_face = ey[DW-1] ? cfim_pkg::FACE_NEG_Y : cfim_pkg::FACE_POS_Y;
        end else begin
            n_face = ex[DW-1] ? cfim_pkg::FACE_NEG_X : cfim_pkg::FACE_POS_X;
        end
        case (n_face)
            cfim_pkg::FACE_POS_X: begin n_norm = mx; n_ta = ey;        n_tb = ez;        end
            cfim_pkg::FACE_POS_Y: begin n_norm = my; n_ta = DW'(-ex);  n_tb = ez;        end
            cfim_pkg::FACE_NEG_X: begin n_norm = mx; n_ta = DW'(-ey);  n_tb = ez;        end
            cfim_pkg::FACE_NEG_Y: begin n_norm = my; n_ta = ex;        n_tb = ez;        end
            cfim_pkg::FACE_POS_Z: begin n_norm = mz; n_ta = ex;        n_tb = ey;        end
            cfim_pkg::FACE_NEG_Z: begin n_norm = mz; n_ta = ex;        n_tb = DW'(-ey);  end
            default:              begin n_norm = mx; n_ta = ey;        n_tb = ez;        end
        endcase
    end

    logic                 r_s2_vld;
    logic                 r_s2_zero;
    logic [FW-1:0]        r_s2_face;
    logic [DW-1:0]        r_s2_norm;
    logic signed [DW-1:0] r_s2_ta, r_s2_tb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
        r_s2_zero <= (r_s1_x == '0) && (r_s1_y == '0) && (r_s1_z == '0);
        r_s2_face <= n_face;
        r_s2_norm <= n_norm;
        r_s2_ta   <= n_ta;
        r_s2_tb   <= n_tb;
    end

    // Stage 3 and on: lane setup, then one rotation per stage
    logic                 r_vld  [0:STEPS];
    logic                 r_zero [0:STEPS];
    logic [FW-1:0]        r_face [0:STEPS];
    cfim_pkg::t_lane      r_la   [0:STEPS];
    cfim_pkg::t_lane      r_lb   [0:STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= r_s2_vld;
        end
        r_zero[0] <= r_s2_zero;
        r_face[0] <= r_s2_face;
        r_la[0]   <= lane_init(r_s2_norm, r_s2_ta);
        r_lb[0]   <= lane_init(r_s2_norm, r_s2_tb);
    end

    for (genvar g = 0; g < STEPS; g++) begin : g_cordic
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else begin
                r_vld[g+1] <= r_vld[g];
            end
            r_zero[g+1] <= r_zero[g];
            r_face[g+1] <= r_face[g];
            r_la[g+1]   <= cordic_step(r_la[g], g);
            r_lb[g+1]   <= cordic_step(r_lb[g], g);
        end
    end

    // Final stage: round, clamp and drive the result strobe
    logic          r_out_vld;
    logic [FW-1:0] r_out_face;
    logic [AW-1:0] r_out_a, r_out_b;
    logic          r_out_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_vld[STEPS];
        end
        r_out_zero <= r_zero[STEPS];
        r_out_face <= r_zero[STEPS] ? '0 : r_face[STEPS];
        r_out_a    <= r_zero[STEPS] ? '0 : lane_result(r_la[STEPS]);
        r_out_b    <= r_zero[STEPS] ? '0 : lane_result(r_lb[STEPS]);
    end

    assign o_result_valid = r_out_vld;
    assign o_face         = r_out_face;
    assign o_angle_a      = $signed(r_out_a);
    assign o_angle_b      = $signed(r_out_b);
    assign o_zero_vector  = r_out_zero;

endmodule

>>> tb/sv/tb.sv
// Testbench for the cube face inverse map: directed and random vectors against a local predictor.
`timescale 1ns / 1ps

module tb;

    // Pipeline depth of the map unit, and the stall limit of the watchdog
    localparam int MAP_LATENCY    = cfim_pkg::CORDIC_STEPS + 4;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef logic signed [cfim_pkg::COORD_WIDTH-1:0] t_coord;

    typedef struct {
        logic [cfim_pkg::FACE_WIDTH-1:0]         face;
        logic signed [cfim_pkg::ANGLE_WIDTH-1:0] angle_a;
        logic signed [cfim_pkg::ANGLE_WIDTH-1:0] angle_b;
        logic                                    zero_vector;
    } t_face_angles;

    // atan(2^-i) in units of 2^-30 rad
    longint atan_q30 [0:31] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
        64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
        64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
        64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
        64'h00000001, 64'h00000000
    };

    logic                                    i_clk;
    logic                                    i_rst_n;
    logic                                    start;
    logic                                    busy;
    t_coord                                  i_pos_x;
    t_coord                                  i_pos_y;
    t_coord                                  i_pos_z;
    logic                                    o_result_valid;
    logic [cfim_pkg::FACE_WIDTH-1:0]         o_face;
    logic signed [cfim_pkg::ANGLE_WIDTH-1:0] o_angle_a;
    logic signed [cfim_pkg::ANGLE_WIDTH-1:0] o_angle_b;
    logic                                    o_zero_vector;

    t_face_angles  pending_maps [$];
    int            vectors_mapped;
    int            zero_vectors_seen;
    int            results_checked;
    int            error_count;
    int            stall_cycles;
    logic [7:0]    faces_seen;
    bit            gaps_enabled;

    cube_face_inverse_map_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .o_result_valid (o_result_valid),
        .o_face         (o_face),
        .o_angle_a      (o_angle_a),
        .o_angle_b      (o_angle_b),
        .o_zero_vector  (o_zero_vector)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Equiangular coordinate atan2(t, n) in Q1.15, for n >= |t|
    function automatic logic signed [cfim_pkg::ANGLE_WIDTH-1:0] equiangular_q15(longint t,
                                                                                longint n);
        longint mag;
        longint x;
        longint y;
        longint z;
        longint nx;
        longint ny;
        longint r;
        mag = (t < 0) ? -t : t;
        if (mag == 0)
            return '0;
        if (mag == n) begin
            r = longint'(cfim_pkg::QUARTER_PI_Q15);
        end else begin
            x = n <<< cfim_pkg::PRESHIFT;
            y = mag <<< cfim_pkg::PRESHIFT;
            z = 0;
            // Vectoring rotations drive y toward zero and sum the angle in z
            for (int i = 0; i < cfim_pkg::CORDIC_STEPS && i < 32; i++) begin
                if (y >= 0) begin
                    nx = x + (y >>> i);
                    ny = y - (x >>> i);
                    z  = z + atan_q30[i];
                end else begin
                    nx = x - (y >>> i);
                    ny = y + (x >>> i);
                    z  = z - atan_q30[i];
                end
                x = nx;
                y = ny;
            end
            r = (z + (64'sd1 <<< 14)) >>> cfim_pkg::ANGLE_FRAC;
            if (r < 0)
                r = 0;
            if (r > longint'(cfim_pkg::QUARTER_PI_Q15))
                r = longint'(cfim_pkg::QUARTER_PI_Q15);
        end
        if (t < 0)
            r = -r;
        return cfim_pkg::ANGLE_WIDTH'(r);
    endfunction

    // Face and both angles of one direction vector
    function automatic t_face_angles map_to_face(t_coord px, t_coord py, t_coord pz);
        t_face_angles res;
        longint vx;
        longint vy;
        longint vz;
        longint ax;
        longint ay;
        longint az;
        longint n;
        longint ta;
        longint tb;
        vx = px;
        vy = py;
        vz = pz;
        res.face        = cfim_pkg::FACE_POS_X;
        res.angle_a     = '0;
        res.angle_b     = '0;
        res.zero_vector = 1'b0;
        if (vx == 0 && vy == 0 && vz == 0) begin
            res.zero_vector = 1'b1;
            return res;
        end
        ax = (vx < 0) ? -vx : vx;
        ay = (vy < 0) ? -vy : vy;
        az = (vz < 0) ? -vz : vz;
        // Largest magnitude wins, ties go to the earlier axis
        if (az > ax && az > ay)
            res.face = (vz >= 0) ? cfim_pkg::FACE_POS_Z : cfim_pkg::FACE_NEG_Z;
        else if (ay > ax)
            res.face = (vy >= 0) ? cfim_pkg::FACE_POS_Y : cfim_pkg::FACE_NEG_Y;
        else
            res.face = (vx >= 0) ? cfim_pkg::FACE_POS_X : cfim_pkg::FACE_NEG_X;
        // Normal and tangent components in the face's own basis
        case (res.face)
            cfim_pkg::FACE_POS_X: begin n =  vx; ta =  vy; tb =  vz; end
            cfim_pkg::FACE_POS_Y: begin n =  vy; ta = -vx; tb =  vz; end
            cfim_pkg::FACE_NEG_X: begin n = -vx; ta = -vy; tb =  vz; end
            cfim_pkg::FACE_NEG_Y: begin n = -vy; ta =  vx; tb =  vz; end
            cfim_pkg::FACE_POS_Z: begin n =  vz; ta =  vx; tb =  vy; end
            default:              begin n = -vz; ta =  vx; tb = -vy; end
        endcase
        res.angle_a = equiangular_q15(ta, n);
        res.angle_b = equiangular_q15(tb, n);
        return res;
    endfunction

    // Predict at each accepted transaction, check each result against the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_face_angles want;
        if (i_rst_n) begin
            if (o_result_valid) begin
                if (pending_maps.size() == 0) begin
                    $error("result with no transaction pending: face %0d a %0d b %0d zero %0b",
                           o_face, o_angle_a, o_angle_b, o_zero_vector);
                    error_count++;
                end else begin
                    want = pending_maps.pop_front();
                    results_checked++;
                    if (o_face !== want.face) begin
                        $error("face: expected %0d, got %0d", want.face, o_face);
                        error_count++;
                    end
                    if (o_angle_a !== want.angle_a) begin
                        $error("angle_a: expected %0d, got %0d", want.angle_a, o_angle_a);
                        error_count++;
                    end
                    if (o_angle_b !== want.angle_b) begin
                        $error("angle_b: expected %0d, got %0d", want.angle_b, o_angle_b);
                        error_count++;
                    end
                    if (o_zero_vector !== want.zero_vector) begin
                        $error("zero_vector: expected %0b, got %0b",
                               want.zero_vector, o_zero_vector);
                        error_count++;
                    end
                    if (want.zero_vector)
                        zero_vectors_seen++;
                    else
                        faces_seen[want.face] = 1'b1;
                end
            end
            if (start && !busy) begin
                pending_maps.push_back(map_to_face(i_pos_x, i_pos_y, i_pos_z));
                vectors_mapped++;
            end
        end
    end

    // Abort when neither side moves a transaction for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("cube_face_inverse_map_unit test failed");
            $finish;
        end
    end

    // Send one vector, with an optional idle burst ahead of it
    task automatic drive_vector(input t_coord vx, input t_coord vy, input t_coord vz);
        int gap;
        if (gaps_enabled && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            repeat (gap) begin
                @(negedge i_clk);
                start   <= 1'b0;
                i_pos_x <= t_coord'($urandom);
                i_pos_y <= t_coord'($urandom);
                i_pos_z <= t_coord'($urandom);
            end
        end
        @(negedge i_clk);
        start   <= 1'b1;
        i_pos_x <= vx;
        i_pos_y <= vy;
        i_pos_z <= vz;
        do @(posedge i_clk); while (busy);
    endtask

    // Hold off the sender until every pending result is out
    task automatic wait_until_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_maps.size() != 0)
            @(posedge i_clk);
    endtask

    // Signed value of magnitude m, 1..32768, with random sign (always negative at 32768)
    function automatic t_coord signed_mag(int m);
        if (m >= 32768)
            return t_coord'(-32768);
        return ($urandom_range(0, 1) != 0) ? t_coord'(-m) : t_coord'(m);
    endfunction

    task automatic test_directed_cases();
        drive_vector(0, 0, 0);
        drive_vector(1000, 200, -300);
        drive_vector(200, 1000, 300);
        drive_vector(-1000, -200, 300);
        drive_vector(200, -1000, -300);
        drive_vector(-200, 300, 1000);
        drive_vector(200, -300, -1000);
        // Ties across axes and tangents equal to the normal
        drive_vector(500, 500, 500);
        drive_vector(-500, 500, -500);
        drive_vector(0, -700, 700);
        drive_vector(1, 1, -1);
        // Extremes, including the most negative component on every axis
        drive_vector(32767, 0, 0);
        drive_vector(-32768, 0, 0);
        drive_vector(-32768, -32768, -32768);
        drive_vector(-32768, 32767, -32767);
        drive_vector(0, 0, -32768);
        drive_vector(0, 32767, -32768);
        drive_vector(32767, -32767, 1);
        drive_vector(32767, 32766, -32766);
        // Small nonzero vectors, including the smallest on each of the three axes
        drive_vector(1, 0, 0);
        drive_vector(0, 0, 1);
        drive_vector(0, -1, 0);
        drive_vector(3, 2, -1);
    endtask

    task automatic test_random_vectors(input int count);
        t_coord vx;
        t_coord vy;
        t_coord vz;
        int     m;
        int     pick;
        repeat (count) begin
            pick = $urandom_range(0, 19);
            m    = $urandom_range(1, 32768);
            vx   = t_coord'($urandom);
            vy   = t_coord'($urandom);
            vz   = t_coord'($urandom);
            case (pick)
                // Small magnitudes: short CORDIC inputs and frequent ties
                8, 9: begin
                    vx = t_coord'(int'($urandom_range(0, 14)) - 7);
                    vy = t_coord'(int'($urandom_range(0, 14)) - 7);
                    vz = t_coord'(int'($urandom_range(0, 14)) - 7);
                end
                // Equal magnitudes on two or three axes
                10, 11: begin
                    vx = signed_mag(m);
                    vy = signed_mag(m);
                    if ($urandom_range(0, 1) != 0)
                        vz = signed_mag(m);
                    else
                        vz = t_coord'($urandom_range(0, m - 1));
                    if ($urandom_range(0, 1) != 0) begin
                        vx = vz;
                        vz = signed_mag(m);
                    end
                end
                // Tangent equal to the normal on one dominant axis
                12, 13: begin
                    vx = signed_mag(m);
                    vy = signed_mag(m);
                    vz = t_coord'(int'($urandom_range(0, m - 1))
                                  * (($urandom_range(0, 1) != 0) ? -1 : 1));
                    if ($urandom_range(0, 1) != 0) begin
                        vz = vx;
                        vx = t_coord'($urandom_range(0, m - 1));
                    end
                end
                // Components drawn from the field extremes
                14, 15: begin
                    vx = (vx[0]) ? t_coord'(-32768)
                                 : ((vx[1]) ? t_coord'(32767) : t_coord'(vx[2]));
                    vy = (vy[0]) ? t_coord'(-32768)
                                 : ((vy[1]) ? t_coord'(32767) : -t_coord'(vy[2]));
                    vz = (vz[0]) ? t_coord'(-32768)
                                 : ((vz[1]) ? t_coord'(-32767) : t_coord'(vz[2]));
                end
                // One dominant axis, the others small
                16, 17: begin
                    case ($urandom_range(0, 2))
                        0: begin vy = vy >>> 6; vz = vz >>> 6; end
                        1: begin vx = vx >>> 6; vz = vz >>> 6; end
                        default: begin vx = vx >>> 6; vy = vy >>> 6; end
                    endcase
                end
                18: begin
                    vx = 0;
                    vy = 0;
                    vz = 0;
                end
                default: ;
            endcase
            drive_vector(vx, vy, vz);
        end
    endtask

    task automatic test_pause_for_drain();
        wait_until_drained();
        test_random_vectors(300);
    endtask

    task automatic test_full_rate();
        gaps_enabled = 1'b0;
        test_random_vectors(330);
    endtask

    initial begin
        i_rst_n           = 1'b0;
        start             = 1'b0;
        i_pos_x           = '0;
        i_pos_y           = '0;
        i_pos_z           = '0;
        vectors_mapped    = 0;
        zero_vectors_seen = 0;
        results_checked   = 0;
        error_count       = 0;
        stall_cycles      = 0;
        faces_seen        = '0;
        gaps_enabled      = 1'b1;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_random_vectors(700);
        test_pause_for_drain();
        test_full_rate();

        // Drain the pipeline and watch for stray results
        wait_until_drained();
        repeat (MAP_LATENCY + 8) @(posedge i_clk);

        $display("Mapped %0d vectors (%0d zero vectors), %0d results checked, %0d mismatches",
                 vectors_mapped, zero_vectors_seen, results_checked, error_count);
        $display("Faces reached (one bit per face code): %b", faces_seen[5:0]);
        if (error_count == 0)
            $display("cube_face_inverse_map_unit test passed");
        else
            $display("cube_face_inverse_map_unit test failed");
        $finish;
    end

endmodule

>>> filelist.f
hdl/cfim_pkg.sv
hdl/cube_face_inverse_map_unit.sv
tb/sv/tb.sv
